// ===== rtl/core/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the character mapping shared by the encoder modules.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [6:0] PAD_CODE = 7'd61;  // '='

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       final_char;
	} char_item_t;

	// One group of three bytes ready to be turned into four characters
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n_pad;  // trailing '=' count: 0, 1 or 2
		logic       last;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic [1:0] fill;
	} front_status_t;

	typedef struct packed {
		logic [1:0] idx;
	} back_status_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		logic [6:0] v7;
		logic [6:0] code;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			code = v7 + 7'd65;
		end else if (v < 6'd52) begin
			code = v7 + 7'd71;
		end else if (v < 6'd62) begin
			code = v7 - 7'd4;
		end else if (v == 6'd62) begin
			code = 7'd43;
		end else begin
			code = 7'd47;
		end
		return code;
	endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into three-byte groups and hands each finished or
// terminated group to the queue.
// ----------------------------------------------------------------------------
module b64e_front
	import b64e_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	input  byte_item_t    byte_data,
	input  queue_status_t q_stat,
	output logic          push,
	output group_t        push_grp,
	output front_status_t fe_stat
);

	logic [1:0] fill_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic       take;

	assign byte_stall     = q_stat.full;
	assign take           = byte_valid && !q_stat.full;
	assign fe_stat.fill   = fill_q;

	always_comb begin
		push     = 1'b0;
		push_grp = '{b0: byte_data.data_byte, b1: 8'd0, b2: 8'd0, n_pad: 2'd2, last: 1'b1};
		case (fill_q)
			2'd1: begin
				push_grp.b0    = held0_q;
				push_grp.b1    = byte_data.data_byte;
				push_grp.n_pad = 2'd1;
				push           = take && byte_data.final_byte;
			end
			2'd2: begin
				push_grp.b0    = held0_q;
				push_grp.b1    = held1_q;
				push_grp.b2    = byte_data.data_byte;
				push_grp.n_pad = 2'd0;
				push_grp.last  = byte_data.final_byte;
				push           = take;
			end
			default: begin
				push = take && byte_data.final_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (take) begin
			if (byte_data.final_byte || fill_q == 2'd2) begin
				fill_q <= 2'd0;
			end else if (fill_q == 2'd1) begin
				fill_q <= 2'd2;
			end else begin
				fill_q <= 2'd1;
			end
		end
	end

	// hold bytes of an unfinished group
	always_ff @(posedge clk) begin
		if (take && !byte_data.final_byte) begin
			if (fill_q == 2'd1) begin
				held1_q <= byte_data.data_byte;
			end else if (fill_q != 2'd2) begin
				held0_q <= byte_data.data_byte;
			end
		end
	end

endmodule

// ===== rtl/core/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between the byte collector and the character serialiser.
// ----------------------------------------------------------------------------
module b64e_queue
	import b64e_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  group_t        push_grp,
	input  logic          pop,
	output group_t        head,
	output queue_status_t q_stat
);

	group_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_grp;
		end
	end

endmodule

// ===== rtl/core/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// Serialises the head group into four characters, one per cycle while
// char_stall is low, through a registered output.
// ----------------------------------------------------------------------------
module b64e_back
	import b64e_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  group_t        head,
	input  queue_status_t q_stat,
	output logic          pop,
	output logic          char_valid,
	input  logic          char_stall,
	output char_item_t    char_data,
	output back_status_t  bk_stat
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	char_item_t out_q;
	logic       advance;
	logic [5:0] sextet;
	char_item_t next_char;

	assign advance      = !out_valid_q || !char_stall;
	assign pop          = advance && !q_stat.empty && (idx_q == 2'd3);
	assign char_valid   = out_valid_q;
	assign char_data    = out_q;
	assign bk_stat.idx  = idx_q;

	always_comb begin
		case (idx_q)
			2'd0:    sextet = head.b0[7:2];
			2'd1:    sextet = {head.b0[1:0], head.b1[7:4]};
			2'd2:    sextet = {head.b1[3:0], head.b2[7:6]};
			default: sextet = head.b2[5:0];
		endcase
		// pad from the end: idx >= 4 - n_pad
		if ({1'b0, idx_q} + {1'b0, head.n_pad} >= 3'd4) begin
			next_char.char_code = PAD_CODE;
		end else begin
			next_char.char_code = sextet_to_ascii(sextet);
		end
		next_char.final_char = head.last && (idx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_char;
		end
	end

endmodule

// ===== rtl/core/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with '=' padding and an end-of-message flag.
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+-------------------------
//  byte    | in        | byte_item_t  | byte_valid / byte_stall
//  char    | out       | char_item_t  | char_valid / char_stall
//
//  Bytes are taken one per cycle until the two-entry group queue fills.
//  Characters leave one per cycle while char_stall is low; the output
//  serialiser sets the sustained rate.
//  Each character is formed combinationally from the queue head and registered in out_q.
//  Reset clears the group fill, queue pointers and output valid.
//  A stall on the output holds the serialiser; the byte side stalls only
//  once the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder
	import b64e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_data,
	output logic       char_valid,
	input  logic       char_stall,
	output char_item_t char_data
);

	queue_status_t q_stat;
	front_status_t fe_stat;
	back_status_t  bk_stat;
	group_t        push_grp;
	group_t        head;
	logic          push;
	logic          pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_grp   (push_grp),
		.fe_stat    (fe_stat)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.bk_stat    (bk_stat)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("group pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!q_stat.empty && bk_stat.idx == 2'd3))
		else $error("group popped out of turn");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fe_stat.fill != 2'd3)
		else $error("group fill out of range");

	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && char_data.char_code == PAD_CODE
			&& !char_data.final_char)
		|=> (char_valid && char_data.char_code == PAD_CODE))
		else $error("padding run broken");

endmodule
